@@ src/assert_macros.svh @@
// Assertion helpers for the files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ src/mbi_pkg.sv @@
package mbi_pkg;

   // Field widths fixed by the register map and the stream format.
   localparam int RowW     = 8;
   localparam int ColW     = 10;
   localparam int LenW     = 16;
   localparam int ProdW    = RowW + ColW;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;
   localparam int WordW    = 32;

   // Remainder unit: one dividend bit per cycle.
   localparam int RemW    = 10;
   localparam int RemCntW = 4;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CsrRowCount    = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrColumnCount = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrBlockLength = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrRowStep     = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrColOffStep  = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrDirection   = 3'd5;
   localparam logic [CsrIdxW-1:0] CsrBypass      = 3'd6;

   // Register values after reset.
   localparam logic [RowW-1:0] RowCountReset    = 8'd40;
   localparam logic [ColW-1:0] ColumnCountReset = 10'd576;
   localparam logic [LenW-1:0] BlockLengthReset = 16'd23040;
   localparam logic [RowW-1:0] RowStepReset     = 8'd9;
   localparam logic [ColW-1:0] ColOffStepReset  = 10'd17;

   typedef enum logic [1:0] {
      StatusOk         = 2'd0,
      StatusBadConfig  = 2'd1,
      StatusOutOfPhase = 2'd2
   } status_type;

   typedef enum logic {
      CmdLoad  = 1'b0,
      CmdFetch = 1'b1
   } command_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       prep_start;
      logic       capture;
      logic       calc;
      logic       fetch_phase;
      logic       mem_wr;
      logic       mem_rd;
      logic       idx_step;
      logic       idx_clear;
      logic       out_load;
      logic       out_read;
      logic       out_last;
      status_type out_status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cfg_write;
      logic prep_done;
      logic cfg_ok;
      logic idx_last;
   } dp_status_type;

endpackage

@@ src/mbi_rem.sv @@
// Restoring remainder unit: dividend mod divisor, one bit per cycle.
module mbi_rem (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [mbi_pkg::RemW-1:0] dividend,
   input  logic [mbi_pkg::RemW-1:0] divisor,
   output logic                     done,
   output logic [mbi_pkg::RemW-1:0] remainder
);

   localparam logic [mbi_pkg::RemCntW-1:0] LastStep = mbi_pkg::RemCntW'(mbi_pkg::RemW - 1);

   logic [mbi_pkg::RemW-1:0]    bits_ff, bits_in;
   logic [mbi_pkg::RemW-1:0]    rem_ff, rem_in;
   logic [mbi_pkg::RemCntW-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [mbi_pkg::RemW:0]      trial;

   // Shift the next dividend bit into the partial remainder and subtract when it fits.
   always_comb begin
      trial   = {rem_ff, bits_ff[mbi_pkg::RemW-1]};
      bits_in = bits_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         bits_in = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         bits_in = {bits_ff[mbi_pkg::RemW-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = mbi_pkg::RemW'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[mbi_pkg::RemW-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ src/mbi_datapath.sv @@
// Configuration registers, address generator, matrix store and result register.
module mbi_datapath #(
   parameter int MAX_BLOCK  = 32768,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mbi_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [mbi_pkg::CsrDataW-1:0]  csr_wdata,
   input  logic [mbi_pkg::WordW-1:0]     req_tdata,
   input  mbi_pkg::dp_cmd_type           cmd,
   output mbi_pkg::dp_status_type        sts,
   output logic [mbi_pkg::WordW-1:0]     rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int AddrW   = $clog2(MAX_BLOCK);
   localparam int LenExtW = mbi_pkg::LenW + 1;
   localparam logic [LenExtW-1:0] MaxBlockLen = LenExtW'(MAX_BLOCK);

   // Configuration registers.
   logic [mbi_pkg::RowW-1:0] row_count_ff;
   logic [mbi_pkg::ColW-1:0] column_count_ff;
   logic [mbi_pkg::LenW-1:0] block_length_ff;
   logic [mbi_pkg::RowW-1:0] row_step_ff;
   logic [mbi_pkg::ColW-1:0] col_off_step_ff;
   logic                     direction_ff;
   logic                     bypass_ff;
   logic                     cfg_write;

   // Configuration check.
   logic [mbi_pkg::ProdW-1:0] rc_prod;
   logic                      cfg_ok_in, cfg_ok_ff;

   // Step sizes reduced modulo rows and columns.
   logic                     row_rem_done, col_rem_done;
   logic [mbi_pkg::RemW-1:0] row_rem, col_rem;
   logic [mbi_pkg::RowW-1:0] row_inc;
   logic [mbi_pkg::ColW-1:0] col_inc;

   // Element index and its row and column trackers.
   logic [mbi_pkg::LenW-1:0] idx_ff, idx_in;
   logic [mbi_pkg::RowW-1:0] row_ff, row_in;
   logic [mbi_pkg::ColW-1:0] cyc_ff, cyc_in;
   logic [mbi_pkg::RowW-1:0] lrow_ff, lrow_in;
   logic [mbi_pkg::ColW-1:0] off_ff, off_in;
   logic [LenExtW-1:0]       idx_next;
   logic [mbi_pkg::RowW:0]   lrow_sum;
   logic [mbi_pkg::ColW:0]   off_sum;
   logic                     row_wrap;

   // Address calculation.
   logic                      use_load;
   logic [mbi_pkg::ColW-1:0]  col_fetch;
   logic [mbi_pkg::RowW-1:0]  row_sel;
   logic [mbi_pkg::ColW-1:0]  col_sel;
   logic [mbi_pkg::ProdW-1:0] prod_ff;
   logic [mbi_pkg::ColW-1:0]  col_ff;
   logic [mbi_pkg::ProdW-1:0] addr_sum;
   logic [AddrW-1:0]          mem_addr;

   // Store and data registers.
   logic [DATA_WIDTH-1:0] mem [MAX_BLOCK];
   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] rd_ff;
   logic [mbi_pkg::WordW-1:0] rsp_data_ff;
   mbi_pkg::status_type       rsp_status_ff;
   logic                      rsp_last_ff;

   // Register writes: only the listed indexes take effect and abort the block.
   assign cfg_write = csr_we && (csr_index <= mbi_pkg::CsrBypass);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= mbi_pkg::RowCountReset;
         column_count_ff <= mbi_pkg::ColumnCountReset;
         block_length_ff <= mbi_pkg::BlockLengthReset;
         row_step_ff     <= mbi_pkg::RowStepReset;
         col_off_step_ff <= mbi_pkg::ColOffStepReset;
         direction_ff    <= 1'b0;
         bypass_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            mbi_pkg::CsrRowCount:    row_count_ff    <= csr_wdata[mbi_pkg::RowW-1:0];
            mbi_pkg::CsrColumnCount: column_count_ff <= csr_wdata[mbi_pkg::ColW-1:0];
            mbi_pkg::CsrBlockLength: block_length_ff <= csr_wdata[mbi_pkg::LenW-1:0];
            mbi_pkg::CsrRowStep:     row_step_ff     <= csr_wdata[mbi_pkg::RowW-1:0];
            mbi_pkg::CsrColOffStep:  col_off_step_ff <= csr_wdata[mbi_pkg::ColW-1:0];
            mbi_pkg::CsrDirection:   direction_ff    <= csr_wdata[0];
            mbi_pkg::CsrBypass:      bypass_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The geometry is checked every cycle and held in a register.
   always_comb begin
      rc_prod   = mbi_pkg::ProdW'(row_count_ff) * mbi_pkg::ProdW'(column_count_ff);
      cfg_ok_in = (block_length_ff != '0) && ({1'b0, block_length_ff} <= MaxBlockLen);
      if (!bypass_ff) begin
         cfg_ok_in = cfg_ok_in && (row_count_ff != '0) && (column_count_ff != '0)
                     && (mbi_pkg::ProdW'(block_length_ff) == rc_prod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ok_ff <= 1'b0;
      end else begin
         cfg_ok_ff <= cfg_ok_in;
      end
   end

   // Step sizes are reduced once after reset or a register write.
   mbi_rem u_row_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.prep_start),
      .dividend  (mbi_pkg::RemW'(row_step_ff)),
      .divisor   (mbi_pkg::RemW'(row_count_ff)),
      .done      (row_rem_done),
      .remainder (row_rem)
   );

   mbi_rem u_col_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.prep_start),
      .dividend  (mbi_pkg::RemW'(col_off_step_ff)),
      .divisor   (mbi_pkg::RemW'(column_count_ff)),
      .done      (col_rem_done),
      .remainder (col_rem)
   );

   assign row_inc = row_rem[mbi_pkg::RowW-1:0];
   assign col_inc = col_rem[mbi_pkg::ColW-1:0];

   // Index trackers: the row wraps at the row count, the load row and the fetch
   // column offset advance by their reduced steps without any division.
   always_comb begin
      idx_next = {1'b0, idx_ff} + 1'b1;
      row_wrap = (row_ff == (row_count_ff - 1'b1));
      lrow_sum = {1'b0, lrow_ff} + {1'b0, row_inc};
      off_sum  = {1'b0, off_ff} + {1'b0, col_inc};
      idx_in   = idx_ff;
      row_in   = row_ff;
      cyc_in   = cyc_ff;
      lrow_in  = lrow_ff;
      off_in   = off_ff;
      if (cfg_write || cmd.idx_clear) begin
         idx_in  = '0;
         row_in  = '0;
         cyc_in  = '0;
         lrow_in = '0;
         off_in  = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_next[mbi_pkg::LenW-1:0];
         if (row_wrap) begin
            row_in  = '0;
            cyc_in  = cyc_ff + 1'b1;
            lrow_in = '0;
            off_in  = '0;
         end else begin
            row_in = row_ff + 1'b1;
            if (lrow_sum >= {1'b0, row_count_ff}) begin
               lrow_in = mbi_pkg::RowW'(lrow_sum - {1'b0, row_count_ff});
            end else begin
               lrow_in = lrow_sum[mbi_pkg::RowW-1:0];
            end
            if (off_sum >= {1'b0, column_count_ff}) begin
               off_in = mbi_pkg::ColW'(off_sum - {1'b0, column_count_ff});
            end else begin
               off_in = off_sum[mbi_pkg::ColW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         row_ff  <= '0;
         cyc_ff  <= '0;
         lrow_ff <= '0;
         off_ff  <= '0;
      end else begin
         idx_ff  <= idx_in;
         row_ff  <= row_in;
         cyc_ff  <= cyc_in;
         lrow_ff <= lrow_in;
         off_ff  <= off_in;
      end
   end

   // Row and column of the current element under the pattern in use. The load
   // pattern serves loads when interleaving and fetches when deinterleaving.
   always_comb begin
      use_load = (cmd.fetch_phase == direction_ff);
      if (cyc_ff >= off_ff) begin
         col_fetch = cyc_ff - off_ff;
      end else begin
         col_fetch = mbi_pkg::ColW'({1'b0, cyc_ff} + {1'b0, column_count_ff} - {1'b0, off_ff});
      end
      row_sel = use_load ? lrow_ff : row_ff;
      col_sel = use_load ? cyc_ff : col_fetch;
   end

   // Row base is multiplied out in its own cycle.
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         prod_ff <= mbi_pkg::ProdW'(row_sel) * mbi_pkg::ProdW'(column_count_ff);
         col_ff  <= col_sel;
      end
   end

   assign addr_sum = prod_ff + mbi_pkg::ProdW'(col_ff);
   assign mem_addr = bypass_ff ? idx_ff[AddrW-1:0] : addr_sum[AddrW-1:0];

   // Input word is held while the item is worked on.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff <= DATA_WIDTH'(req_tdata);
      end
   end

   // Matrix store: one write or one read per element.
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[mem_addr] <= word_ff;
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // Result register: it holds a finished result while the next item is accepted.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff   <= cmd.out_read ? mbi_pkg::WordW'(rd_ff) : '0;
         rsp_status_ff <= cmd.out_status;
         rsp_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_status_ff;
   assign rsp_tlast = rsp_last_ff;

   assign sts.cfg_write = cfg_write;
   assign sts.prep_done = row_rem_done && col_rem_done;
   assign sts.cfg_ok    = cfg_ok_ff;
   assign sts.idx_last  = (idx_next >= {1'b0, block_length_ff});

endmodule

@@ src/mbi_ctrl.sv @@
// Controller: sequences one item at a time and tracks the load or drain phase.
module mbi_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  mbi_pkg::dp_status_type        sts,
   output mbi_pkg::dp_cmd_type           cmd
);

   typedef enum logic [2:0] {
      StPrep,
      StPrepWait,
      StIdle,
      StCalc,
      StMem,
      StFinish
   } state_type;

   state_type           state_ff;
   logic                draining_ff;
   logic                rsp_valid_ff;
   logic                fetch_ff;
   logic                last_ff;
   mbi_pkg::status_type status_ff;
   logic                accept;
   logic                out_free;
   logic                is_fetch;

   assign accept   = (state_ff == StIdle) && req_tvalid;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_fetch = (req_tuser == mbi_pkg::CmdFetch);

   // Commands decoded from the state.
   always_comb begin
      cmd             = '0;
      cmd.prep_start  = (state_ff == StPrep);
      cmd.capture     = accept;
      cmd.calc        = (state_ff == StCalc);
      cmd.fetch_phase = draining_ff;
      cmd.mem_wr      = (state_ff == StMem) && !fetch_ff;
      cmd.mem_rd      = (state_ff == StMem) && fetch_ff;
      cmd.idx_step    = (state_ff == StMem) && !sts.idx_last;
      cmd.idx_clear   = (state_ff == StMem) && sts.idx_last;
      cmd.out_load    = (state_ff == StFinish) && out_free;
      cmd.out_read    = fetch_ff && (status_ff == mbi_pkg::StatusOk);
      cmd.out_last    = last_ff;
      cmd.out_status  = status_ff;
   end

   // State, phase and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StPrep;
         draining_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fetch_ff     <= 1'b0;
         last_ff      <= 1'b0;
         status_ff    <= mbi_pkg::StatusOk;
      end else begin
         // A new result replaces the one leaving in the same cycle.
         if (!sts.cfg_write && (state_ff == StFinish) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (sts.cfg_write) begin
            state_ff    <= StPrep;
            draining_ff <= 1'b0;
         end else begin
            case (state_ff)
               StPrep: begin
                  state_ff <= StPrepWait;
               end
               StPrepWait: begin
                  if (sts.prep_done) begin
                     state_ff <= StIdle;
                  end
               end
               StIdle: begin
                  if (req_tvalid) begin
                     fetch_ff <= is_fetch;
                     last_ff  <= 1'b0;
                     if (!sts.cfg_ok) begin
                        status_ff <= mbi_pkg::StatusBadConfig;
                        state_ff  <= StFinish;
                     end else if (is_fetch != draining_ff) begin
                        status_ff <= mbi_pkg::StatusOutOfPhase;
                        state_ff  <= StFinish;
                     end else begin
                        status_ff <= mbi_pkg::StatusOk;
                        state_ff  <= StCalc;
                     end
                  end
               end
               StCalc: begin
                  state_ff <= StMem;
               end
               StMem: begin
                  // The load that fills the block starts draining; the fetch
                  // that empties it flags the end and returns to loading.
                  if (sts.idx_last) begin
                     if (fetch_ff) begin
                        last_ff     <= 1'b1;
                        draining_ff <= 1'b0;
                     end else begin
                        draining_ff <= 1'b1;
                     end
                  end
                  state_ff <= StFinish;
               end
               StFinish: begin
                  if (out_free) begin
                     state_ff <= StIdle;
                  end
               end
               default: begin
                  state_ff <= StPrep;
               end
            endcase
         end
      end
   end

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ src/matrix_block_interleaver_top.sv @@
// Rows-by-columns block interleaver.
// Input stream (req_): each transfer is one command. tuser selects load or
// fetch; tdata carries the word to load. Loads fill the matrix store until the
// block length is reached, then fetches read it back in permuted order (load
// order in bypass). Result stream (rsp_): exactly one transfer per command,
// carrying the fetched word (zero for loads and errors), a status code in tuser
// and tlast on the final fetch of a block.
// Configuration (csr_): a write to any listed register aborts the block in
// progress and the phase returns to loading.
// A load or fetch goes through accept, row multiply, store access and result
// load, and the next command is taken only after the result load. A command
// refused for bad settings or wrong phase skips the row multiply and store
// access. The result register lets the next command be taken while a result
// still waits.
// After reset and after every register write, the step sizes are reduced by
// bit-serial remainder units; req_tready stays low until both are done.
// If the receiver stalls, the held result stays and at most one further command
// is worked on, then input stalls too.
`include "assert_macros.svh"

module matrix_block_interleaver_top #(
   parameter int MAX_BLOCK  = 32768,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mbi_pkg::WordW-1:0]     req_tdata,   // [31:0] data_in
   input  logic                          req_tuser,   // [0] command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mbi_pkg::WordW-1:0]     rsp_tdata,   // [31:0] data_out
   output logic [1:0]                    rsp_tuser,   // [1:0] status
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [mbi_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [mbi_pkg::CsrDataW-1:0]  csr_wdata
);

   mbi_pkg::dp_cmd_type    dp_cmd;
   mbi_pkg::dp_status_type dp_sts;

   mbi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (dp_sts),
      .cmd        (dp_cmd)
   );

   mbi_datapath #(
      .MAX_BLOCK  (MAX_BLOCK),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (dp_cmd),
      .sts       (dp_sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // No input is taken while the store is being accessed.
   `ASSERT_IMPLY(a_mem_blocks_input, clock, reset, dp_cmd.mem_wr || dp_cmd.mem_rd, !req_tready)

   // A register write restarts step preparation before any further input.
   `ASSERT_NEXT(a_csr_stalls_input, clock, reset, csr_we && (csr_index <= mbi_pkg::CsrBypass), !req_tready)

   // A loaded result is presented on the next cycle.
   `ASSERT_NEXT(a_result_presented, clock, reset, dp_cmd.out_load, rsp_tvalid)

   // The end-of-block flag only comes with a successful fetch.
   `ASSERT_IMPLY(a_last_on_fetch, clock, reset, dp_cmd.out_load && dp_cmd.out_last, dp_cmd.out_read)

endmodule

@@ tb/sv/matrix_block_interleaver_top_test.sv @@
`timescale 1ns / 1ps

module matrix_block_interleaver_top_test;

   localparam int MaxBlock   = 32768;
   localparam int TargetCmds = 1800;

   typedef struct packed {
      mbi_pkg::command_type      cmd;
      logic [mbi_pkg::WordW-1:0] word;
   } command_item_type;

   typedef struct packed {
      logic [mbi_pkg::WordW-1:0] word;
      mbi_pkg::status_type       status;
      logic                      last;
   } result_item_type;

   // Clock, reset and every input of the block start at known values.
   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [mbi_pkg::WordW-1:0]    req_tdata  = '0;
   logic                         req_tuser  = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [mbi_pkg::WordW-1:0]    rsp_tdata;
   logic [1:0]                   rsp_tuser;
   logic                         rsp_tlast;
   logic                         csr_we     = 1'b0;
   logic [mbi_pkg::CsrIdxW-1:0]  csr_index  = '0;
   logic [mbi_pkg::CsrDataW-1:0] csr_wdata  = '0;

   matrix_block_interleaver_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Predictor copy of the register file and of the block state.
   logic [mbi_pkg::RowW-1:0]  cfg_rows;
   logic [mbi_pkg::ColW-1:0]  cfg_cols;
   logic [mbi_pkg::LenW-1:0]  cfg_len;
   logic [mbi_pkg::RowW-1:0]  cfg_row_step;
   logic [mbi_pkg::ColW-1:0]  cfg_col_step;
   logic                      cfg_deinterleave;
   logic                      cfg_bypass;
   int                        loaded_count;
   int                        fetched_count;
   bit                        draining;
   logic [mbi_pkg::WordW-1:0] matrix_mem [MaxBlock];
   bit                        mem_written [MaxBlock];

   command_item_type queued_cmds [$];
   result_item_type  due_results [$];
   command_item_type held_cmd;
   result_item_type  rsp_want;
   int               send_gap;
   int               recv_stall;
   bit               steady;
   int               fail_count;
   int               commands_queued;
   int               commands_sent;
   int               results_checked;
   int               settings_used;
   int               blocks_done;
   int               status_seen [3];

   // The register settings give a usable block geometry.
   function automatic bit settings_valid();
      if (cfg_len == 0 || cfg_len > MaxBlock) return 1'b0;
      if (cfg_bypass) return 1'b1;
      if (cfg_rows == 0 || cfg_cols == 0) return 1'b0;
      return int'(cfg_len) == int'(cfg_rows) * int'(cfg_cols);
   endfunction

   // Scatter pattern: the row advances by the row step, one column per sweep.
   function automatic int scatter_addr(int i);
      int rows;
      int cols;
      rows = cfg_rows;
      cols = cfg_cols;
      return ((i % rows) * int'(cfg_row_step) % rows) * cols + i / rows;
   endfunction

   // Gather pattern: each row is read with its column shifted back by a step per row.
   function automatic int gather_addr(int i);
      int rows;
      int cols;
      int offset;
      rows   = cfg_rows;
      cols   = cfg_cols;
      offset = (i % rows) * int'(cfg_col_step) % cols;
      return (i % rows) * cols + (i / rows + cols - offset) % cols;
   endfunction

   function automatic int element_addr(int i, bit by_scatter);
      if (cfg_bypass) return i % MaxBlock;
      return (by_scatter ? scatter_addr(i) : gather_addr(i)) % MaxBlock;
   endfunction

   // Works out the result of one accepted command and advances the state.
   function automatic result_item_type interleave_command(command_item_type item);
      result_item_type res;
      int              addr;
      res.word   = '0;
      res.status = mbi_pkg::StatusOk;
      res.last   = 1'b0;
      if (!settings_valid()) begin
         res.status = mbi_pkg::StatusBadConfig;
      end else if (item.cmd == mbi_pkg::CmdLoad) begin
         if (draining) begin
            res.status = mbi_pkg::StatusOutOfPhase;
         end else begin
            addr = element_addr(loaded_count, !cfg_deinterleave);
            matrix_mem[addr]  = item.word;
            mem_written[addr] = 1'b1;
            loaded_count = (loaded_count + 1) & 16'hFFFF;
            if (loaded_count >= cfg_len) begin
               draining      = 1'b1;
               fetched_count = 0;
            end
         end
      end else if (!draining) begin
         res.status = mbi_pkg::StatusOutOfPhase;
      end else begin
         res.word = matrix_mem[element_addr(fetched_count, cfg_deinterleave)];
         fetched_count = (fetched_count + 1) & 16'hFFFF;
         if (fetched_count >= cfg_len) begin
            res.last      = 1'b1;
            draining      = 1'b0;
            loaded_count  = 0;
            fetched_count = 0;
            blocks_done++;
         end
      end
      status_seen[int'(res.status)]++;
      return res;
   endfunction

   // A register write also abandons the block in progress.
   function automatic void apply_register(logic [mbi_pkg::CsrIdxW-1:0] index,
                                          logic [mbi_pkg::CsrDataW-1:0] value);
      case (index)
         mbi_pkg::CsrRowCount:    cfg_rows         = value[mbi_pkg::RowW-1:0];
         mbi_pkg::CsrColumnCount: cfg_cols         = value[mbi_pkg::ColW-1:0];
         mbi_pkg::CsrBlockLength: cfg_len          = value[mbi_pkg::LenW-1:0];
         mbi_pkg::CsrRowStep:     cfg_row_step     = value[mbi_pkg::RowW-1:0];
         mbi_pkg::CsrColOffStep:  cfg_col_step     = value[mbi_pkg::ColW-1:0];
         mbi_pkg::CsrDirection:   cfg_deinterleave = value[0];
         mbi_pkg::CsrBypass:      cfg_bypass       = value[0];
         default:                 return;
      endcase
      loaded_count  = 0;
      fetched_count = 0;
      draining      = 1'b0;
   endfunction

   // With a row step that shares a factor with the row count the scatter
   // misses whole rows; the gather must then only hit words written earlier.
   function automatic bit gather_covered();
      bit row_hit [256];
      int r;
      int c;
      if (cfg_bypass || cfg_deinterleave || !settings_valid()) return 1'b1;
      for (r = 0; r < cfg_rows; r++) row_hit[(r * int'(cfg_row_step)) % cfg_rows] = 1'b1;
      for (r = 0; r < cfg_rows; r++) begin
         if (!row_hit[r]) begin
            for (c = 0; c < cfg_cols; c++) begin
               if (!mem_written[r * cfg_cols + c]) return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   // Mostly short gaps, now and then a long one; none in a steady stretch.
   function automatic int idle_cycles();
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(8, 4);
      return $urandom_range(40, 15);
   endfunction

   function automatic logic [mbi_pkg::WordW-1:0] random_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h1 << $urandom_range(31);
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_command(mbi_pkg::command_type cmd,
                                logic [mbi_pkg::WordW-1:0] word);
      command_item_type item;
      item.cmd  = cmd;
      item.word = word;
      queued_cmds.push_back(item);
      commands_queued++;
   endtask

   // Idle means nothing queued, nothing offered and no result outstanding.
   task automatic wait_until_idle();
      do @(negedge clock);
      while (queued_cmds.size() != 0 || req_tvalid || due_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Called just after a rising edge; the write happens at the next one.
   task automatic write_register(logic [mbi_pkg::CsrIdxW-1:0] index, int value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[mbi_pkg::CsrDataW-1:0];
      @(posedge clock);
      apply_register(index, value[mbi_pkg::CsrDataW-1:0]);
   endtask

   task automatic write_single(logic [mbi_pkg::CsrIdxW-1:0] index, int value);
      wait_until_idle();
      write_register(index, value);
      csr_we <= 1'b0;
   endtask

   task automatic program_settings(input int rows, input int cols, input int len,
                                   input int row_step, input int col_step,
                                   input int deint, input int bypass);
      wait_until_idle();
      write_register(mbi_pkg::CsrRowCount, rows);
      write_register(mbi_pkg::CsrColumnCount, cols);
      write_register(mbi_pkg::CsrBlockLength, len);
      write_register(mbi_pkg::CsrRowStep, row_step);
      write_register(mbi_pkg::CsrColOffStep, col_step);
      write_register(mbi_pkg::CsrDirection, deint);
      write_register(mbi_pkg::CsrBypass, bypass);
      if (!gather_covered()) write_register(mbi_pkg::CsrRowStep, 1);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // One whole block: loads, then fetches, with an odd command out of phase.
   task automatic queue_block(int len, int noise_pct);
      int n;
      for (n = 0; n < len; n++) begin
         if ($urandom_range(99) < noise_pct) queue_command(mbi_pkg::CmdFetch, $urandom());
         queue_command(mbi_pkg::CmdLoad, random_word());
      end
      for (n = 0; n < len; n++) begin
         if ($urandom_range(99) < noise_pct) queue_command(mbi_pkg::CmdLoad, random_word());
         queue_command(mbi_pkg::CmdFetch, $urandom());
      end
   endtask

   // One random phase: full blocks, a partly loaded block, or broken settings.
   task automatic random_phase();
      int kind;
      int rows;
      int cols;
      int len;
      int row_step;
      int bypass;
      int n;
      kind   = $urandom_range(99);
      steady = ($urandom_range(3) == 0);
      if (kind < 70) begin
         rows = $urandom_range(8, 1);
         cols = $urandom_range(10, 1);
         if ($urandom_range(9) == 0) begin
            rows = $urandom_range(40, 9);
            cols = $urandom_range(3, 1);
         end
         if ($urandom_range(19) == 0) begin
            rows = 255;
            cols = 1;
         end
         row_step = ($urandom_range(9) == 0) ? 255 : $urandom_range(rows + 3);
         bypass   = ($urandom_range(99) < 15);
         len      = bypass ? $urandom_range(64, 1) : rows * cols;
         program_settings(rows, cols, len, row_step, $urandom_range(1023),
                          $urandom_range(1), bypass);
         repeat ($urandom_range(3, 1)) queue_block(cfg_len, 4);
      end else if (kind < 85) begin
         // The next register write abandons this block half loaded.
         rows   = $urandom_range(255);
         cols   = $urandom_range(1023);
         bypass = ($urandom_range(99) < 30);
         len    = bypass ? $urandom_range(MaxBlock, 1) : rows * cols;
         program_settings(rows, cols, len, $urandom_range(255), $urandom_range(1023),
                          $urandom_range(1), bypass);
         if (settings_valid() && cfg_len > 1) begin
            n = $urandom_range((cfg_len - 1 < 40) ? cfg_len - 1 : 40, 1);
            repeat (n) begin
               if ($urandom_range(9) == 0) queue_command(mbi_pkg::CmdFetch, $urandom());
               queue_command(mbi_pkg::CmdLoad, random_word());
            end
         end else begin
            repeat (2) queue_command(mbi_pkg::command_type'($urandom_range(1)),
                                     random_word());
         end
      end else begin
         rows = $urandom_range(16, 1);
         cols = $urandom_range(16, 1);
         case ($urandom_range(4))
            0: program_settings(0, cols, $urandom_range(100, 1), 1, 1, 0, 0);
            1: program_settings(rows, 0, $urandom_range(100, 1), 1, 1, 0, 0);
            2: program_settings(rows, cols, rows * cols + 1, 1, 1, $urandom_range(1), 0);
            3: program_settings(rows, cols, 0, 1, 1, 0, 1);
            default: program_settings(rows, cols, $urandom_range(65535, MaxBlock + 1),
                                      1, 1, 0, 1);
         endcase
         repeat ($urandom_range(4, 1))
            queue_command(mbi_pkg::command_type'($urandom_range(1)), random_word());
      end
   endtask

   // Driver: offers queued commands and runs the predictor on each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_results.push_back(interleave_command(held_cmd));
            commands_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0 || queued_cmds.size() == 0) begin
               req_tvalid <= 1'b0;
               if (send_gap != 0) send_gap--;
            end else begin
               held_cmd = queued_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= held_cmd.cmd;
               req_tdata  <= held_cmd.word;
               send_gap = idle_cycles();
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 30)
                  $display("%0t: result with nothing expected: data %h status %0d last %b",
                           $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               rsp_want = due_results.pop_front();
               if (rsp_tdata !== rsp_want.word) begin
                  fail_count++;
                  if (fail_count <= 30)
                     $display("%0t: data_out expected %h, actual %h",
                              $time, rsp_want.word, rsp_tdata);
               end
               if (rsp_tuser !== rsp_want.status) begin
                  fail_count++;
                  if (fail_count <= 30)
                     $display("%0t: status expected %0d, actual %0d",
                              $time, rsp_want.status, rsp_tuser);
               end
               if (rsp_tlast !== rsp_want.last) begin
                  fail_count++;
                  if (fail_count <= 30)
                     $display("%0t: last expected %b, actual %b",
                              $time, rsp_want.last, rsp_tlast);
               end
               results_checked++;
            end
            recv_stall = idle_cycles();
         end
         if (recv_stall == 0 && !steady && $urandom_range(19) == 0) recv_stall = idle_cycles();
         if (recv_stall != 0) begin
            rsp_tready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus: directed cases first, then random phases.
   initial begin
      cfg_rows         = mbi_pkg::RowCountReset;
      cfg_cols         = mbi_pkg::ColumnCountReset;
      cfg_len          = mbi_pkg::BlockLengthReset;
      cfg_row_step     = mbi_pkg::RowStepReset;
      cfg_col_step     = mbi_pkg::ColOffStepReset;
      cfg_deinterleave = 1'b0;
      cfg_bypass       = 1'b0;
      loaded_count     = 0;
      fetched_count    = 0;
      draining         = 1'b0;
      steady           = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Settings after reset: a fetch while loading, then a load.
      queue_command(mbi_pkg::CmdFetch, '0);
      queue_command(mbi_pkg::CmdLoad, '1);

      // Small block with extreme words; a load while draining; last on the final fetch.
      program_settings(2, 3, 6, 1, 1, 0, 0);
      queue_command(mbi_pkg::CmdLoad, 32'h0000_0000);
      queue_command(mbi_pkg::CmdLoad, 32'hFFFF_FFFF);
      queue_command(mbi_pkg::CmdLoad, 32'hAAAA_AAAA);
      queue_command(mbi_pkg::CmdLoad, 32'h5555_5555);
      queue_command(mbi_pkg::CmdLoad, 32'h0000_0001);
      queue_command(mbi_pkg::CmdLoad, 32'h8000_0000);
      queue_command(mbi_pkg::CmdLoad, 32'h1234_5678);
      repeat (6) queue_command(mbi_pkg::CmdFetch, '1);

      // Register writes abandon a block, both while loading and while draining.
      program_settings(1, 2, 2, 1, 1, 0, 0);
      queue_command(mbi_pkg::CmdLoad, 32'hDEAD_BEEF);
      write_single(mbi_pkg::CsrDirection, 0);
      queue_command(mbi_pkg::CmdLoad, 32'hCAFE_F00D);
      queue_command(mbi_pkg::CmdFetch, '0);
      queue_command(mbi_pkg::CmdLoad, 32'h0BAD_F00D);
      write_single(mbi_pkg::CsrBypass, 0);
      queue_command(mbi_pkg::CmdFetch, '0);

      // Broken settings: zero rows, length unequal to the product, bypass with
      // zero length, lengths beyond the store.
      program_settings(0, 3, 0, 1, 1, 0, 0);
      queue_command(mbi_pkg::CmdLoad, 32'h0000_FFFF);
      queue_command(mbi_pkg::CmdFetch, '0);
      program_settings(4, 4, 15, 1, 1, 0, 0);
      queue_command(mbi_pkg::CmdLoad, 32'hFFFF_0000);
      program_settings(4, 4, 0, 1, 1, 0, 1);
      queue_command(mbi_pkg::CmdFetch, '0);
      program_settings(64, 1000, 64000, 1, 1, 0, 0);
      queue_command(mbi_pkg::CmdLoad, 32'h7FFF_FFFF);
      program_settings(1, 1, 65535, 1, 1, 0, 1);
      queue_command(mbi_pkg::CmdLoad, 32'h0000_0002);

      // Largest bypass block, deinterleave selected, zero steps; left half loaded.
      program_settings(1, 1, MaxBlock, 0, 0, 1, 1);
      queue_command(mbi_pkg::CmdLoad, 32'hF0F0_F0F0);

      while (commands_queued < TargetCmds) random_phase();

      wait_until_idle();
      repeat (8) @(posedge clock);
      $display("Run covered %0d commands under %0d settings; %0d blocks read back in full.",
               commands_sent, settings_used, blocks_done);
      $display("Statuses: %0d ok, %0d invalid configuration, %0d out of phase; %0d checked.",
               status_seen[mbi_pkg::StatusOk], status_seen[mbi_pkg::StatusBadConfig],
               status_seen[mbi_pkg::StatusOutOfPhase], results_checked);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("Timeout with %0d commands queued and %0d results outstanding.",
               queued_cmds.size(), due_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/mbi_pkg.sv
src/mbi_rem.sv
src/mbi_datapath.sv
src/mbi_ctrl.sv
src/matrix_block_interleaver_top.sv
tb/sv/matrix_block_interleaver_top_test.sv
